// ===== sv/gcm_pkg.sv =====
// gcm_pkg: shared types, codes and field widths for the grid cell mover
// used by the channel interfaces, controller, datapath and top level
package gcm_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 6;
  localparam int MAT_W  = 4;
  localparam int DIR_W  = 4;
  localparam int STEP_W = 7;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [DIR_W-1:0] DIR_DOWN      = 4'd1;
  localparam logic [DIR_W-1:0] DIR_UP        = 4'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT      = 4'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT     = 4'd4;
  localparam logic [DIR_W-1:0] DIR_LEFTDOWN  = 4'd5;
  localparam logic [DIR_W-1:0] DIR_LEFTUP    = 4'd6;
  localparam logic [DIR_W-1:0] DIR_RIGHTDOWN = 4'd7;
  localparam logic [DIR_W-1:0] DIR_RIGHTUP   = 4'd8;

  typedef struct packed {
    logic col_dec;
    logic col_inc;
    logic row_dec;
    logic row_inc;
  } dir_step_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_WRITE,
    RES_HELD,
    RES_BLANK,
    RES_MOVE
  } res_kind_t;

  typedef struct packed {
    logic      clear;
    logic      load;
    logic      wr_cell;
    logic      rd_start;
    logic      rd_next;
    logic      cap_start;
    logic      step;
    logic      clr_src;
    logic      put_dst;
    logic      out_load;
    res_kind_t res;
  } ctrl_t;

  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] cmd;
    logic             in_grid;
    logic             steps_zero;
    logic             last_step;
    logic             first_step;
    logic             cell_empty;
  } stat_t;

  function automatic dir_step_t dir_step(input logic [DIR_W-1:0] dir);
    dir_step_t s;
    s = '0;
    case (dir)
      DIR_DOWN:      s.row_dec = 1'b1;
      DIR_UP:        s.row_inc = 1'b1;
      DIR_LEFT:      s.col_dec = 1'b1;
      DIR_RIGHT:     s.col_inc = 1'b1;
      DIR_LEFTDOWN:  begin s.col_dec = 1'b1; s.row_dec = 1'b1; end
      DIR_LEFTUP:    begin s.col_dec = 1'b1; s.row_inc = 1'b1; end
      DIR_RIGHTDOWN: begin s.col_inc = 1'b1; s.row_dec = 1'b1; end
      DIR_RIGHTUP:   begin s.col_inc = 1'b1; s.row_inc = 1'b1; end
      default:       s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/gcm_chan_if.sv =====
// gcm_chan_if: valid/ready channel interfaces for commands and results
// depends on gcm_pkg for the field widths
interface gcm_in_if;
  logic                        valid;
  logic                        ready;
  logic [gcm_pkg::CMD_W-1:0]   command;
  logic [gcm_pkg::POS_W-1:0]   col;
  logic [gcm_pkg::POS_W-1:0]   row;
  logic [gcm_pkg::MAT_W-1:0]   material;
  logic [gcm_pkg::DIR_W-1:0]   direction;
  logic [gcm_pkg::STEP_W-1:0]  step_length;

  modport source (output valid, command, col, row, material, direction, step_length,
                  input ready);
  modport sink (input valid, command, col, row, material, direction, step_length,
                output ready);
endinterface

interface gcm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       moved;
  logic [gcm_pkg::MAT_W-1:0]  cell_material;
  logic [gcm_pkg::POS_W-1:0]  end_col;
  logic [gcm_pkg::POS_W-1:0]  end_row;

  modport source (output valid, moved, cell_material, end_col, end_row, input ready);
  modport sink (input valid, moved, cell_material, end_col, end_row, output ready);
endinterface

// ===== sv/gcm_ctrl.sv =====
// gcm_ctrl: sequencer for clear, write, read and move commands
// depends on gcm_pkg for the command and status structs
module gcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  gcm_pkg::stat_t  st,
  output gcm_pkg::ctrl_t  ctl
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_FIRST,
    S_CHECK,
    S_CLR_SRC,
    S_PUT_DST,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  gcm_pkg::res_kind_t  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    ctl       = '0;
    ctl.res   = res_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (st.cmd)
          gcm_pkg::CMD_WRITE: begin
            ctl.wr_cell = 1'b1;
            res_nxt     = gcm_pkg::RES_WRITE;
            state_nxt   = S_FINISH;
          end
          gcm_pkg::CMD_READ, gcm_pkg::CMD_MOVE: begin
            if (st.in_grid) begin
              ctl.rd_start = 1'b1;
              state_nxt    = S_FIRST;
            end else begin
              res_nxt   = gcm_pkg::RES_BLANK;
              state_nxt = S_FINISH;
            end
          end
          default: begin
            res_nxt   = gcm_pkg::RES_NONE;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FIRST: begin
        ctl.cap_start = 1'b1;
        if (st.cmd == gcm_pkg::CMD_READ) begin
          res_nxt   = gcm_pkg::RES_HELD;
          state_nxt = S_FINISH;
        end else if (st.steps_zero) begin
          state_nxt = S_CLR_SRC;
        end else begin
          ctl.rd_next = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.cell_empty) begin
          ctl.step = 1'b1;
          if (st.last_step) state_nxt = S_CLR_SRC;
          else ctl.rd_next = 1'b1;
        end else if (st.first_step) begin
          res_nxt   = gcm_pkg::RES_HELD;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CLR_SRC;
        end
      end
      S_CLR_SRC: begin
        ctl.clr_src = 1'b1;
        state_nxt   = S_PUT_DST;
      end
      S_PUT_DST: begin
        ctl.put_dst = 1'b1;
        res_nxt     = gcm_pkg::RES_MOVE;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      res_r       <= gcm_pkg::RES_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_dst_after_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT_DST) |-> ($past(state_r) == S_CLR_SRC))
    else $error("destination write without clearing the start cell");

endmodule

// ===== sv/gcm_dp.sv =====
// gcm_dp: grid memory, walk position registers and result register
// depends on gcm_pkg; driven by gcm_ctrl through ctrl_t, reports through stat_t
module gcm_dp #(
  parameter int GRID_W   = 64,
  parameter int GRID_H   = 64,
  parameter int MAT_BITS = 4,
  parameter int MAX_STEP = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gcm_pkg::ctrl_t                 ctl,
  output gcm_pkg::stat_t                 st,
  input  logic [gcm_pkg::CFG_W-1:0]      width_in_use,
  input  logic [gcm_pkg::CFG_W-1:0]      height_in_use,
  input  logic [gcm_pkg::CMD_W-1:0]      in_command,
  input  logic [gcm_pkg::POS_W-1:0]      in_col,
  input  logic [gcm_pkg::POS_W-1:0]      in_row,
  input  logic [gcm_pkg::MAT_W-1:0]      in_material,
  input  logic [gcm_pkg::DIR_W-1:0]      in_direction,
  input  logic [gcm_pkg::STEP_W-1:0]     in_step_length,
  output logic                           out_moved,
  output logic [gcm_pkg::MAT_W-1:0]      out_cell_material,
  output logic [gcm_pkg::POS_W-1:0]      out_end_col,
  output logic [gcm_pkg::POS_W-1:0]      out_end_row
);

  localparam int CW    = $clog2(GRID_W);
  localparam int RW    = $clog2(GRID_H);
  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_STEP + 1);

  logic [MAT_BITS-1:0]           mem [DEPTH];
  logic [MAT_BITS-1:0]           rd_data_r;
  logic [AW-1:0]                 clr_addr_r;

  logic [gcm_pkg::CMD_W-1:0]     cmd_r;
  logic [gcm_pkg::POS_W-1:0]     col_r, row_r;
  logic [gcm_pkg::MAT_W-1:0]     material_r;
  gcm_pkg::dir_step_t            dstep_r;
  logic [SW-1:0]                 steps_r, n_r;
  logic                          inside_r;
  logic [CW-1:0]                 start_col_r, walk_col_r, tgt_col_r;
  logic [RW-1:0]                 start_row_r, walk_row_r, tgt_row_r;
  logic [MAT_BITS-1:0]           start_mat_r;

  logic                          moved_r;
  logic [gcm_pkg::MAT_W-1:0]     mat_out_r;
  logic [gcm_pkg::POS_W-1:0]     end_col_r, end_row_r;

  logic [CW-1:0]                 lim_col, col_nxt;
  logic [RW-1:0]                 lim_row, row_nxt;
  logic [SW-1:0]                 steps_sat;
  logic                          inside_in;
  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_addr;
  logic [MAT_BITS-1:0]           mem_wdata;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(r * GRID_W + c);
  endfunction

  always_comb begin
    if (width_in_use == '0) lim_col = '0;
    else if (width_in_use > GRID_W) lim_col = CW'(GRID_W - 1);
    else lim_col = CW'(width_in_use - 7'd1);
    if (height_in_use == '0) lim_row = '0;
    else if (height_in_use > GRID_H) lim_row = RW'(GRID_H - 1);
    else lim_row = RW'(height_in_use - 7'd1);
  end

  assign inside_in = (in_col <= lim_col) && (in_row <= lim_row);

  always_comb begin
    if (in_step_length > MAX_STEP) steps_sat = SW'(MAX_STEP);
    else steps_sat = SW'(in_step_length);
  end

  // clamped single step from the current target
  always_comb begin
    col_nxt = tgt_col_r;
    if (dstep_r.col_dec && tgt_col_r != '0) col_nxt = tgt_col_r - 1'b1;
    else if (dstep_r.col_inc && tgt_col_r != lim_col) col_nxt = tgt_col_r + 1'b1;
    row_nxt = tgt_row_r;
    if (dstep_r.row_dec && tgt_row_r != '0) row_nxt = tgt_row_r - 1'b1;
    else if (dstep_r.row_inc && tgt_row_r != lim_row) row_nxt = tgt_row_r + 1'b1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_of(start_col_r, start_row_r);
    mem_wdata = '0;
    if (ctl.clear) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_r;
    end else if (ctl.wr_cell) begin
      mem_we    = inside_r;
      mem_wdata = MAT_BITS'(material_r);
    end else if (ctl.clr_src) begin
      mem_we = 1'b1;
    end else if (ctl.put_dst) begin
      mem_we    = 1'b1;
      mem_addr  = addr_of(walk_col_r, walk_row_r);
      mem_wdata = start_mat_r;
    end else if (ctl.rd_start) begin
      mem_re = 1'b1;
    end else if (ctl.rd_next) begin
      mem_re   = 1'b1;
      mem_addr = addr_of(col_nxt, row_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (ctl.clear) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r       <= in_command;
      col_r       <= in_col;
      row_r       <= in_row;
      material_r  <= in_material;
      dstep_r     <= gcm_pkg::dir_step(in_direction);
      steps_r     <= steps_sat;
      inside_r    <= inside_in;
      start_col_r <= CW'(in_col);
      start_row_r <= RW'(in_row);
      walk_col_r  <= CW'(in_col);
      walk_row_r  <= RW'(in_row);
      tgt_col_r   <= CW'(in_col);
      tgt_row_r   <= RW'(in_row);
      n_r         <= '0;
    end else begin
      if (ctl.step) begin
        walk_col_r <= tgt_col_r;
        walk_row_r <= tgt_row_r;
        n_r        <= n_r + 1'b1;
      end
      if (ctl.rd_next) begin
        tgt_col_r <= col_nxt;
        tgt_row_r <= row_nxt;
      end
    end
    if (ctl.cap_start) start_mat_r <= rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.res)
        gcm_pkg::RES_WRITE: begin
          moved_r   <= 1'b0;
          mat_out_r <= gcm_pkg::MAT_W'(MAT_BITS'(material_r));
          end_col_r <= col_r;
          end_row_r <= row_r;
        end
        gcm_pkg::RES_HELD: begin
          moved_r   <= 1'b0;
          mat_out_r <= gcm_pkg::MAT_W'(start_mat_r);
          end_col_r <= col_r;
          end_row_r <= row_r;
        end
        gcm_pkg::RES_BLANK: begin
          moved_r   <= 1'b0;
          mat_out_r <= '0;
          end_col_r <= col_r;
          end_row_r <= row_r;
        end
        gcm_pkg::RES_MOVE: begin
          moved_r   <= 1'b1;
          mat_out_r <= gcm_pkg::MAT_W'(start_mat_r);
          end_col_r <= gcm_pkg::POS_W'(walk_col_r);
          end_row_r <= gcm_pkg::POS_W'(walk_row_r);
        end
        default: begin
          moved_r   <= 1'b0;
          mat_out_r <= '0;
          end_col_r <= '0;
          end_row_r <= '0;
        end
      endcase
    end
  end

  assign st.clr_last   = (clr_addr_r == AW'(DEPTH - 1));
  assign st.cmd        = cmd_r;
  assign st.in_grid    = inside_r;
  assign st.steps_zero = (steps_r == '0);
  assign st.last_step  = (SW'(n_r + 1'b1) == steps_r);
  assign st.first_step = (n_r == '0);
  assign st.cell_empty = (rd_data_r == '0);

  assign out_moved         = moved_r;
  assign out_cell_material = mat_out_r;
  assign out_end_col       = end_col_r;
  assign out_end_row       = end_row_r;

endmodule

// ===== sv/grid_cell_mover_core.sv =====
// grid_cell_mover_core: top level of the grid cell mover
// depends on gcm_pkg, gcm_chan_if, gcm_ctrl and gcm_dp
//
// A grid of GRID_W x GRID_H material codes in one single-port memory, with
// write, read and move commands on a valid/ready channel and one result beat
// per command. After reset the block sweeps the grid to empty, one cell a
// cycle, before it takes its first command. A write, an unused command or an
// address outside the grid in use goes straight to its result and a read
// first reads the start cell; a move ends early when its first step is
// blocked and otherwise walks at most step_length steps (step_length
// saturated at MAX_STEP), reading one grid cell per step through the single
// memory port, and then writes the start and end cells. The next command is
// taken in the cycle after the result is loaded; a result still waiting on
// the output holds the finished command until it is taken.
module grid_cell_mover_core #(
  parameter int GRID_W   = 64,
  parameter int GRID_H   = 64,
  parameter int MAT_BITS = 4,
  parameter int MAX_STEP = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gcm_in_if.sink                      in_ch,
  gcm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [gcm_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [gcm_pkg::CFG_W-1:0]   cfg_data
);

  logic [gcm_pkg::CFG_W-1:0] width_in_use_r, height_in_use_r;
  gcm_pkg::ctrl_t            ctl;
  gcm_pkg::stat_t            st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_in_use_r  <= 7'd64;
      height_in_use_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_idx)
        gcm_pkg::REG_WIDTH:  width_in_use_r  <= cfg_data;
        gcm_pkg::REG_HEIGHT: height_in_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .ctl       (ctl)
  );

  gcm_dp #(
    .GRID_W   (GRID_W),
    .GRID_H   (GRID_H),
    .MAT_BITS (MAT_BITS),
    .MAX_STEP (MAX_STEP)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .st                (st),
    .width_in_use      (width_in_use_r),
    .height_in_use     (height_in_use_r),
    .in_command        (in_ch.command),
    .in_col            (in_ch.col),
    .in_row            (in_ch.row),
    .in_material       (in_ch.material),
    .in_direction      (in_ch.direction),
    .in_step_length    (in_ch.step_length),
    .out_moved         (out_ch.moved),
    .out_cell_material (out_ch.cell_material),
    .out_end_col       (out_ch.end_col),
    .out_end_row       (out_ch.end_row)
  );

endmodule
